// ===== design/mmc_pkg.sv =====
// Package for the magnetometer min/max calibrator: types, constants, reset values.
// No dependencies; used by mmc_lane, mmc_merge, the top level and the test bench.
`timescale 1ns / 1ps
package mmc_pkg;

  localparam int unsigned NumAxes   = 3;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned RangeW    = 17;
  localparam int unsigned RatioW    = 18;
  localparam int unsigned BiasW     = 21;
  localparam int unsigned CalW      = 20;
  localparam int unsigned SettleW   = 16;
  localparam int unsigned QuotW     = 31;

  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindTick   = 2'd1;
  localparam logic [1:0] KindStart  = 2'd2;

  localparam logic [RatioW-1:0]  RatioOne = 18'd16384;
  localparam logic [RatioW-1:0]  RatioMax = 18'd262143;
  localparam logic [SettleW-1:0] SettleReset = 16'd500;

  localparam logic [RatioW-1:0] RatioRstX = 18'd16713;
  localparam logic [RatioW-1:0] RatioRstY = 18'd16384;
  localparam logic [RatioW-1:0] RatioRstZ = 18'd17859;
  localparam logic signed [BiasW-1:0] BiasRstX = 21'sd3420;
  localparam logic signed [BiasW-1:0] BiasRstY = -21'sd3224;
  localparam logic signed [BiasW-1:0] BiasRstZ = 21'sd2003;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CalW-1:0]    cal_t;
  typedef logic [RatioW-1:0]         ratio_t;
  typedef logic signed [BiasW-1:0]   bias_t;

  // Finishing sequencer states.
  localparam logic [1:0] FinIdle  = 2'd0;
  localparam logic [1:0] FinDiv   = 2'd1;
  localparam logic [1:0] FinBias  = 2'd2;
  localparam logic [1:0] FinDone  = 2'd3;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } fin_ctrl_t;

endpackage

// ===== design/mmc_lane.sv =====
// One axis lane: min/max tracking, calibration multiply-add, ratio divider, bias.
// Depends on mmc_pkg.
`timescale 1ns / 1ps
module mmc_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mmc_pkg::ratio_t                  ratio_rst_i,
  input  mmc_pkg::bias_t                   bias_rst_i,
  input  logic                             seed_i,
  input  logic                             track_i,
  input  mmc_pkg::sample_t                 sample_i,
  output logic                             moved_o,
  output logic [mmc_pkg::RangeW-1:0]       range_o,
  input  mmc_pkg::sample_t                 mul_sample_i,
  output mmc_pkg::cal_t                    cal_o,
  input  logic                             div_start_i,
  input  logic                             is_big_i,
  input  logic [mmc_pkg::RangeW-1:0]       big_i,
  output logic                             div_busy_o,
  input  logic                             bias_load_i
);

  mmc_pkg::sample_t min_q, min_d, max_q, max_d;
  mmc_pkg::ratio_t  ratio_q, ratio_d;
  mmc_pkg::bias_t   bias_q, bias_d;

  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    moved_o = 1'b0;
    if (seed_i) begin
      min_d = sample_i;
      max_d = sample_i;
    end else if (track_i) begin
      if (sample_i > max_q) begin
        max_d   = sample_i;
        moved_o = 1'b1;
      end
      if (sample_i < min_q) begin
        min_d   = sample_i;
        moved_o = 1'b1;
      end
    end
  end

  assign range_o = mmc_pkg::RangeW'($signed({max_q[15], max_q}) - $signed({min_q[15], min_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // Calibrated output: (ratio*raw + bias*1024) / 16384, toward zero, saturated.
  logic signed [35:0] acc;
  logic signed [35:0] quo;
  always_comb begin
    acc = $signed({18'd0, ratio_q}) * 36'(mul_sample_i) + (36'(bias_q) <<< 10);
    quo = (acc < 0) ? -((-acc) >>> 14) : (acc >>> 14);
    if (quo > 36'sd524287)       cal_o = 20'sh7ffff;
    else if (quo < -36'sd524288) cal_o = 20'sh80000;
    else                         cal_o = mmc_pkg::CalW'(quo);
  end

  // Restoring divider: (big << 14) / range, one quotient bit per cycle.
  logic [mmc_pkg::QuotW-1:0] num_q, num_d;
  logic [mmc_pkg::RangeW:0]  rem_q, rem_d;
  logic [4:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic [mmc_pkg::RangeW:0]  trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[mmc_pkg::RangeW-1:0], num_q[mmc_pkg::QuotW-1]};
    if (div_start_i) begin
      num_d  = {big_i, 14'd0};
      rem_d  = '0;
      cnt_d  = 5'(mmc_pkg::QuotW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, range_o}) begin
        rem_d = trial - {1'b0, range_o};
        num_d = {num_q[mmc_pkg::QuotW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[mmc_pkg::QuotW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end
  assign div_busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  // Ratio from the quotient, then bias = ratio*(range - 2*max)/2048.
  mmc_pkg::ratio_t new_ratio;
  always_comb begin
    if (is_big_i)                       new_ratio = mmc_pkg::RatioOne;
    else if (range_o == '0)             new_ratio = mmc_pkg::RatioMax;
    else if (num_d > 31'(mmc_pkg::RatioMax)) new_ratio = mmc_pkg::RatioMax;
    else                                new_ratio = mmc_pkg::RatioW'(num_d);
  end

  logic signed [18:0] offs;
  logic signed [38:0] prod;
  logic signed [38:0] bq;
  assign offs = $signed({2'b00, range_o}) - ($signed({{3{max_q[15]}}, max_q}) <<< 1);
  assign prod = $signed({21'd0, ratio_q}) * 39'(offs);
  assign bq   = (prod < 0) ? -((-prod) >>> 11) : (prod >>> 11);

  always_comb begin
    ratio_d = ratio_q;
    bias_d  = bias_q;
    if (div_start_i) begin
      ratio_d = ratio_q;
    end
    if (bias_load_i) begin
      if (bq > 39'sd1048575)       bias_d = 21'sh0fffff;
      else if (bq < -39'sd1048576) bias_d = 21'sh100000;
      else                         bias_d = mmc_pkg::BiasW'(bq);
    end
  end

  // Ratio loads when the divider finishes; bias loads later, while the sequencer is in FinBias.
  logic ratio_load;
  assign ratio_load = busy_q && !busy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= ratio_rst_i;
      bias_q  <= bias_rst_i;
    end else begin
      ratio_q <= ratio_load ? new_ratio : ratio_d;
      bias_q  <= bias_d;
    end
  end

endmodule

// ===== design/mmc_merge.sv =====
// Merge stage: picks the largest axis range; any tie for the largest goes to Z, even a smaller Z.
// Depends on mmc_pkg.
`timescale 1ns / 1ps
module mmc_merge (
  input  logic [mmc_pkg::RangeW-1:0] range_x_i,
  input  logic [mmc_pkg::RangeW-1:0] range_y_i,
  input  logic [mmc_pkg::RangeW-1:0] range_z_i,
  output logic [2:0]                 big_sel_o,
  output logic [mmc_pkg::RangeW-1:0] big_o
);
  always_comb begin
    if (range_x_i > range_y_i && range_x_i > range_z_i) begin
      big_sel_o = 3'b001;
      big_o     = range_x_i;
    end else if (range_y_i > range_x_i && range_y_i > range_z_i) begin
      big_sel_o = 3'b010;
      big_o     = range_y_i;
    end else begin
      big_sel_o = 3'b100;
      big_o     = range_z_i;
    end
  end
endmodule

// ===== design/magnetometer_minmax_calibrator_top.sv =====
// Top level of the magnetometer min/max calibrator: control, lanes, merge, output register.
// Depends on mmc_pkg, mmc_lane and mmc_merge.
`timescale 1ns / 1ps
// An item is taken in, and its result is registered and offered on the next cycle;
// the input is closed while a result waits. A tick that completes calibration first
// lets the three axis lanes each run a radix-2 divider for their ratio (31 quotient
// bits); then the sequencer hands over, computes the biases in FinBias and registers
// the result in FinDone. Samples are calibrated with the ratios and biases in force
// before the item.
module magnetometer_minmax_calibrator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic signed [15:0] sample_x_i,
  input  logic signed [15:0] sample_y_i,
  input  logic signed [15:0] sample_z_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [19:0] cal_x_o,
  output logic signed [19:0] cal_y_o,
  output logic signed [19:0] cal_z_o,
  output logic        calibrating_o,
  output logic        calibrated_o,
  output logic        finished_now_o
);

  logic [15:0] settle_q;
  logic        seeded_q, learning_q, done_q;
  logic [15:0] quiet_q;
  logic [1:0]  fin_q, fin_d;
  logic        ovalid_q;
  mmc_pkg::fin_ctrl_t fctl;

  logic accept;
  assign in_ready_o = !ovalid_q && fin_q == mmc_pkg::FinIdle;
  assign accept     = in_valid_i && in_ready_o;

  logic is_sample, is_tick, is_start;
  assign is_sample = accept && kind_i == mmc_pkg::KindSample;
  assign is_tick   = accept && kind_i == mmc_pkg::KindTick;
  assign is_start  = accept && kind_i == mmc_pkg::KindStart;

  logic seed, track;
  assign seed  = is_sample && learning_q && !seeded_q;
  assign track = is_sample && learning_q && seeded_q;

  mmc_pkg::sample_t s [3];
  assign s[0] = sample_x_i;
  assign s[1] = sample_y_i;
  assign s[2] = sample_z_i;

  mmc_pkg::ratio_t rrst [3];
  mmc_pkg::bias_t  brst [3];
  assign rrst[0] = mmc_pkg::RatioRstX;
  assign rrst[1] = mmc_pkg::RatioRstY;
  assign rrst[2] = mmc_pkg::RatioRstZ;
  assign brst[0] = mmc_pkg::BiasRstX;
  assign brst[1] = mmc_pkg::BiasRstY;
  assign brst[2] = mmc_pkg::BiasRstZ;

  logic [2:0] moved, busy, big_sel;
  logic [mmc_pkg::RangeW-1:0] range [3];
  logic [mmc_pkg::RangeW-1:0] big;
  mmc_pkg::cal_t cal [3];

  // Finishing check after the saturating increment; settle of zero acts as one.
  logic [15:0] quiet_inc;
  logic        finish;
  assign quiet_inc = (quiet_q == 16'hffff) ? quiet_q : quiet_q + 16'd1;
  assign finish    = is_tick && learning_q && seeded_q && (quiet_inc >= settle_q);

  assign fctl.start = finish;
  assign fctl.busy  = |busy;
  assign fctl.done  = fin_q == mmc_pkg::FinBias;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    mmc_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ratio_rst_i  (rrst[a]),
      .bias_rst_i   (brst[a]),
      .seed_i       (seed),
      .track_i      (track),
      .sample_i     (s[a]),
      .moved_o      (moved[a]),
      .range_o      (range[a]),
      .mul_sample_i (s[a]),
      .cal_o        (cal[a]),
      .div_start_i  (fctl.start),
      .is_big_i     (big_sel[a]),
      .big_i        (big),
      .div_busy_o   (busy[a]),
      .bias_load_i  (fctl.done)
    );
  end

  mmc_merge u_merge (
    .range_x_i (range[0]),
    .range_y_i (range[1]),
    .range_z_i (range[2]),
    .big_sel_o (big_sel),
    .big_o     (big)
  );

  always_comb begin
    fin_d = fin_q;
    case (fin_q)
      mmc_pkg::FinIdle: if (fctl.start) fin_d = mmc_pkg::FinDiv;
      mmc_pkg::FinDiv:  if (!fctl.busy) fin_d = mmc_pkg::FinBias;
      mmc_pkg::FinBias: fin_d = mmc_pkg::FinDone;
      mmc_pkg::FinDone: fin_d = mmc_pkg::FinIdle;
      default:          fin_d = mmc_pkg::FinIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= mmc_pkg::SettleReset;
      seeded_q   <= 1'b0;
      learning_q <= 1'b0;
      done_q     <= 1'b0;
      quiet_q    <= '0;
      fin_q      <= mmc_pkg::FinIdle;
      ovalid_q   <= 1'b0;
      finished_now_o <= 1'b0;
      calibrating_o  <= 1'b0;
      calibrated_o   <= 1'b0;
    end else begin
      fin_q <= fin_d;
      if (cfg_we_i) settle_q <= cfg_wdata_i;
      if (is_start) begin
        learning_q <= 1'b1;
        seeded_q   <= 1'b0;
        quiet_q    <= '0;
      end else if (seed) begin
        seeded_q <= 1'b1;
        quiet_q  <= '0;
      end else if (track && |moved) begin
        quiet_q <= '0;
      end else if (is_tick && learning_q && seeded_q) begin
        quiet_q <= quiet_inc;
      end
      if (finish) begin
        learning_q <= 1'b0;
        done_q     <= 1'b1;
      end
      // Result of a finishing tick waits until the new ratios and biases land.
      if (accept && !finish) begin
        ovalid_q       <= 1'b1;
        finished_now_o <= 1'b0;
        calibrating_o  <= is_start | learning_q;
        calibrated_o   <= done_q;
      end else if (fin_q == mmc_pkg::FinDone) begin
        ovalid_q       <= 1'b1;
        finished_now_o <= 1'b1;
        calibrating_o  <= 1'b0;
        calibrated_o   <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cal_x_o <= is_sample ? cal[0] : '0;
      cal_y_o <= is_sample ? cal[1] : '0;
      cal_z_o <= is_sample ? cal[2] : '0;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

// ===== design/mmc_checker.sv =====
// Port-level checker for the magnetometer min/max calibrator, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module mmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [19:0] cal_x_o,
  input logic        calibrating_o,
  input logic        calibrated_o,
  input logic        finished_now_o
);
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input open while a result waits");
  a_fin_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_now_o) |-> (calibrated_o && !calibrating_o))
    else $error("finish result with wrong flags");
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_now_o) |-> cal_x_o == 20'd0)
    else $error("finish result carries data");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(cal_x_o)))
    else $error("stalled result changed");
endmodule

bind magnetometer_minmax_calibrator_top mmc_checker u_mmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .cal_x_o        (cal_x_o),
  .calibrating_o  (calibrating_o),
  .calibrated_o   (calibrated_o),
  .finished_now_o (finished_now_o)
);

// ===== test/mmc_scoreboard.sv =====
// Scoreboard for the magnetometer min/max calibrator: predicts every result and compares.
// Depends on mmc_pkg; instantiated by the testbench top beside the block.
`timescale 1ns / 1ps
module mmc_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic signed [15:0] sample_x_i,
  input  logic signed [15:0] sample_y_i,
  input  logic signed [15:0] sample_z_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic signed [19:0] cal_x_i,
  input  logic signed [19:0] cal_y_i,
  input  logic signed [19:0] cal_z_i,
  input  logic        calibrating_i,
  input  logic        calibrated_i,
  input  logic        finished_now_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    mmc_pkg::cal_t cal[3];
    logic calibrating;
    logic calibrated;
    logic finished_now;
  } cal_result_t;

  cal_result_t result_q[$];

  logic [15:0] settle_q;
  logic        seeded_q;
  logic        learning_q;
  logic        done_q;
  int          min_q[3];
  int          max_q[3];
  int unsigned quiet_q;
  longint      ratio_q[3];
  longint      bias_q[3];
  int          fails = 0;

  assign pending_o    = result_q.size();
  assign fail_count_o = fails;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Derive new ratios and biases from the learned extremes.
  task automatic solve_iron();
    longint rng[3];
    int     big;
    longint p;
    for (int a = 0; a < 3; a++) rng[a] = longint'(max_q[a]) - longint'(min_q[a]);
    if (rng[0] > rng[1] && rng[0] > rng[2]) big = 0;
    else if (rng[1] > rng[0] && rng[1] > rng[2]) big = 1;
    else big = 2;
    for (int a = 0; a < 3; a++) begin
      if (a == big) ratio_q[a] = mmc_pkg::RatioOne;
      else if (rng[a] == 0) ratio_q[a] = mmc_pkg::RatioMax;
      else ratio_q[a] = clip((rng[big] <<< 14) / rng[a], 0, mmc_pkg::RatioMax);
      p = ratio_q[a] * (rng[a] - 2 * longint'(max_q[a]));
      bias_q[a] = clip(p / 2048, -1048576, 1048575);
    end
    learning_q = 1'b0;
    done_q = 1'b1;
  endtask

  task automatic predict_item(input logic [1:0] kind, input int s[3]);
    cal_result_t r;
    logic moved;
    r.cal = '{default: '0};
    r.finished_now = 1'b0;
    if (kind == mmc_pkg::KindSample) begin
      if (learning_q) begin
        if (!seeded_q) begin
          for (int a = 0; a < 3; a++) begin
            min_q[a] = s[a];
            max_q[a] = s[a];
          end
          seeded_q = 1'b1;
          quiet_q = 0;
        end else begin
          moved = 1'b0;
          for (int a = 0; a < 3; a++) begin
            if (s[a] > max_q[a]) begin max_q[a] = s[a]; moved = 1'b1; end
            if (s[a] < min_q[a]) begin min_q[a] = s[a]; moved = 1'b1; end
          end
          if (moved) quiet_q = 0;
        end
      end
      for (int a = 0; a < 3; a++)
        r.cal[a] = mmc_pkg::cal_t'(clip((ratio_q[a] * s[a] + bias_q[a] * 1024) / 16384,
                                        -524288, 524287));
    end else if (kind == mmc_pkg::KindTick) begin
      if (learning_q && seeded_q) begin
        if (quiet_q < 65535) quiet_q++;
        if (quiet_q >= settle_q) begin
          solve_iron();
          r.finished_now = 1'b1;
        end
      end
    end else if (kind == mmc_pkg::KindStart) begin
      learning_q = 1'b1;
      seeded_q = 1'b0;
      quiet_q = 0;
    end
    r.calibrating = learning_q;
    r.calibrated = done_q;
    result_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int s[3];
    cal_result_t w;
    if (!rst_ni) begin
      settle_q   = mmc_pkg::SettleReset;
      seeded_q   = 1'b0;
      learning_q = 1'b0;
      done_q     = 1'b0;
      quiet_q    = 0;
      min_q      = '{0, 0, 0};
      max_q      = '{0, 0, 0};
      ratio_q    = '{mmc_pkg::RatioRstX, mmc_pkg::RatioRstY, mmc_pkg::RatioRstZ};
      bias_q     = '{longint'(mmc_pkg::BiasRstX), longint'(mmc_pkg::BiasRstY),
                     longint'(mmc_pkg::BiasRstZ)};
    end else begin
      if (cfg_we_i) settle_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        s = '{int'(sample_x_i), int'(sample_y_i), int'(sample_z_i)};
        predict_item(kind_i, s);
      end
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          w = result_q.pop_front();
          if (cal_x_i !== w.cal[0]) report_mismatch("cal_x", cal_x_i, w.cal[0]);
          if (cal_y_i !== w.cal[1]) report_mismatch("cal_y", cal_y_i, w.cal[1]);
          if (cal_z_i !== w.cal[2]) report_mismatch("cal_z", cal_z_i, w.cal[2]);
          if (calibrating_i !== w.calibrating)
            report_mismatch("calibrating", calibrating_i, w.calibrating);
          if (calibrated_i !== w.calibrated)
            report_mismatch("calibrated", calibrated_i, w.calibrated);
          if (finished_now_i !== w.finished_now)
            report_mismatch("finished_now", finished_now_i, w.finished_now);
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
// Testbench top for the magnetometer min/max calibrator: clock, reset, stimulus, verdict.
// Depends on mmc_pkg, magnetometer_minmax_calibrator_top and mmc_scoreboard.
`timescale 1ns / 1ps
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic signed [15:0] sample_x_i, sample_y_i, sample_z_i;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [19:0] cal_x_o, cal_y_o, cal_z_o;
  logic        calibrating_o, calibrated_o, finished_now_o;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_reqs;
  int unsigned settle_now;
  int item_count;

  magnetometer_minmax_calibrator_top u_dut (.*);

  mmc_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .kind_i,
    .sample_x_i, .sample_y_i, .sample_z_i, .cfg_we_i, .cfg_wdata_i,
    .out_valid_i(out_valid_o), .out_ready_i, .cal_x_i(cal_x_o), .cal_y_i(cal_y_o),
    .cal_z_i(cal_z_o), .calibrating_i(calibrating_o), .calibrated_i(calibrated_o),
    .finished_now_i(finished_now_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off per request.
  always @(posedge clk_i) begin
    int hold_left;
    int hold_seen;
    if (hold_reqs != hold_seen && hold_left == 0) begin
      hold_seen = hold_reqs;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [1:0] kind, input int x, input int y, input int z);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    sample_x_i <= 16'(x);
    sample_y_i <= 16'(y);
    sample_z_i <= 16'(z);
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    item_count++;
  endtask

  // Write the settle register once the block has drained.
  task automatic write_settle(input logic [15:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settle_now = value;
  endtask

  task automatic learn_run();
    int n, cx, cy, cz, spread, ticks;
    n = $urandom_range(1, 12);
    spread = ($urandom_range(9) == 0) ? 32767 : $urandom_range(1, 3000);
    cx = $urandom_range(0, 65535) - 32768;
    cy = $urandom_range(0, 65535) - 32768;
    cz = $urandom_range(0, 65535) - 32768;
    send_item(mmc_pkg::KindStart, $urandom, $urandom, $urandom);
    for (int i = 0; i < n; i++) begin
      send_item(mmc_pkg::KindSample, cx + $urandom_range(0, 2 * spread) - spread,
                cy + $urandom_range(0, 2 * spread) - spread,
                cz + $urandom_range(0, 2 * spread) - spread);
      if ($urandom_range(3) == 0) send_item(mmc_pkg::KindTick, $urandom, $urandom, $urandom);
    end
    ticks = (settle_now <= 20) ? settle_now + $urandom_range(0, 2) : $urandom_range(1, 5);
    for (int i = 0; i < ticks; i++) send_item(mmc_pkg::KindTick, $urandom, $urandom, $urandom);
    for (int i = $urandom_range(0, 3); i > 0; i--)
      send_item(mmc_pkg::KindSample, $urandom, $urandom, $urandom);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = mmc_pkg::KindSample;
    sample_x_i = '0;
    sample_y_i = '0;
    sample_z_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    hold_reqs = 0;
    send_idle_pct = 34;
    recv_idle_pct = 78;
    settle_now = 500;
    item_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset coefficients, ignored ticks, kind three, restart, ties, zero ranges.
    send_item(mmc_pkg::KindSample, 32767, -32768, 0);
    send_item(mmc_pkg::KindSample, -32768, 32767, -1);
    send_item(mmc_pkg::KindTick, 0, 0, 0);
    send_item(2'd3, 1, 2, 3);
    write_settle(16'd1);
    send_item(mmc_pkg::KindStart, 0, 0, 0);
    send_item(mmc_pkg::KindTick, 0, 0, 0);
    send_item(mmc_pkg::KindSample, 32767, -32768, 5);
    send_item(mmc_pkg::KindStart, 0, 0, 0);
    send_item(mmc_pkg::KindSample, 100, 100, 100);
    send_item(mmc_pkg::KindTick, 0, 0, 0);
    send_item(mmc_pkg::KindSample, 32767, -32768, -32768);
    send_item(mmc_pkg::KindSample, -32768, 32767, 32767);
    send_item(mmc_pkg::KindStart, 0, 0, 0);
    send_item(mmc_pkg::KindSample, 10, 0, 0);
    send_item(mmc_pkg::KindSample, -10, 5, 3);
    send_item(mmc_pkg::KindTick, 0, 0, 0);
    send_item(mmc_pkg::KindStart, 0, 0, 0);
    send_item(mmc_pkg::KindSample, -32768, -32768, 0);
    send_item(mmc_pkg::KindSample, -32760, 32767, 1);
    send_item(mmc_pkg::KindTick, 0, 0, 0);
    send_item(mmc_pkg::KindSample, 32767, -32768, 32767);
    write_settle(16'd0);
    send_item(mmc_pkg::KindStart, 0, 0, 0);
    send_item(mmc_pkg::KindSample, 7, -7, 7);
    send_item(mmc_pkg::KindTick, 0, 0, 0);

    while (item_count < 1030) begin
      if (item_count > 380 && send_idle_pct == 34) begin
        send_idle_pct = 78;
        recv_idle_pct = 34;
        hold_reqs++;
      end
      if (item_count > 730 && send_idle_pct == 78) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        hold_reqs++;
      end
      case ($urandom_range(19))
        0: write_settle(16'($urandom_range(1, 20)));
        1: write_settle(($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom));
        2, 3: send_item(2'($urandom), $urandom, $urandom, $urandom);
        default: learn_run();
      endcase
      if (settle_now > 20 && $urandom_range(2) == 0) write_settle(16'($urandom_range(1, 6)));
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
